FILE: sv/smpe_pkg.sv
package smpe_pkg;

   // event kinds carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_MOTION = 2'd0,
      FUNC_BUTTON = 2'd1,
      FUNC_SYNC   = 2'd2,
      FUNC_DRAIN  = 2'd3
   } func_type;

   // button codes
   localparam logic [2:0] BTN_LEFT   = 3'd0;
   localparam logic [2:0] BTN_MIDDLE = 3'd1;
   localparam logic [2:0] BTN_RIGHT  = 3'd2;

   // packet constants
   localparam logic [1:0] PKT_HEAD_TAG  = 2'b01;
   localparam logic [7:0] PKT_MIDDLE_ON = 8'h20;
   localparam logic [1:0] PKT_LAST3     = 2'd2;
   localparam logic [1:0] PKT_LAST4     = 2'd3;
   localparam logic [2:0] PKT_LEN3      = 3'd3;
   localparam logic [2:0] PKT_LEN4      = 3'd4;

   // most bytes sent for one word
   localparam int         SEND_W   = 6;
   localparam logic [5:0] MAX_SEND = 6'd32;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_WRITE,
      ST_CALC,
      ST_READ,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic build;
      logic write;
      logic calc;
      logic read;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fits;
      logic write_last;
      logic send_zero;
      logic more;
   } status_type;

endpackage

FILE: sv/serial_mouse_packet_encoder.sv
// Serial mouse packet encoder. Words on req_ are events selected by req_tuser: motion adds
// the low 8 bits of the signed value to the X or Y accumulator, button sets left, middle or
// right, sync builds a 3-byte packet (4 bytes when middle is down or has changed), clears the
// accumulators and queues it, and both sync and drain then send min(room, fill, 32) bytes from
// the queue head on rsp_, one word per byte, with rsp_tlast on the final byte of the event.
// A packet that does not fit the QUEUE_DEPTH-byte queue is dropped. Motion and button events
// are taken in the idle state. A sync builds the packet, writes each packet byte through the
// single queue write port, and sizes the send; a drain only sizes the send. Sending then
// starts with the first queue read, after which one byte leaves per cycle while rsp_tready is
// high. A new event is taken once the last byte is gone.
module serial_mouse_packet_encoder #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // axis_select, motion_value, button_select, button_down, room
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte
   output logic        rsp_tlast   // is_last
);
   import smpe_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   smpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // accumulators, packet builder and byte queue
   smpe_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_tuser),
      .req_axis_select   (req_tdata[0]),
      .req_motion_value  (req_tdata[16:1]),
      .req_button_select (req_tdata[19:17]),
      .req_button_down   (req_tdata[20]),
      .req_room          (req_tdata[26:21]),
      .rsp_out_byte      (rsp_tdata),
      .rsp_is_last       (rsp_tlast)
   );

endmodule

FILE: sv/smpe_ctrl.sv
module smpe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_func,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output smpe_pkg::cmd_type     cmd,
   input  smpe_pkg::status_type  status
);
   import smpe_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SYNC) begin
                  state_in = ST_BUILD;
               end else if (req_func == FUNC_DRAIN) begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_BUILD: begin
            state_in = status.fits ? ST_WRITE : ST_CALC;
         end
         ST_WRITE: begin
            if (status.write_last) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = status.send_zero ? ST_IDLE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready && !status.more) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and commands
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = accept;
         end
         ST_BUILD: begin
            cmd.build = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            cmd.read   = rsp_tready && status.more;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/smpe_dp.sv
module smpe_dp #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smpe_pkg::cmd_type     cmd,
   output smpe_pkg::status_type  status,
   input  logic [1:0]            req_func,
   input  logic                  req_axis_select,
   input  logic [15:0]           req_motion_value,
   input  logic [2:0]            req_button_select,
   input  logic                  req_button_down,
   input  logic [5:0]            req_room,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_is_last
);
   import smpe_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > SEND_W) ? CNT_W : SEND_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);

   logic [7:0]        mem [QUEUE_DEPTH];
   logic [7:0]        sum_x_ff;
   logic [7:0]        sum_y_ff;
   logic              left_ff;
   logic              right_ff;
   logic              middle_ff;
   logic              middle_chg_ff;
   logic [5:0]        room_ff;
   logic [7:0]        pkt_ff [4];
   logic              len4_ff;
   logic [1:0]        idx_ff;
   logic [PTR_W-1:0]  head_ff;
   logic [PTR_W-1:0]  tail_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SEND_W-1:0] left_n_ff;
   logic [7:0]        rd_data_ff;

   logic              len4;
   logic [CNT_W:0]    fill_sum;
   logic [SEND_W-1:0] room_lim;
   logic [CMP_W-1:0]  room_ext;
   logic [CMP_W-1:0]  count_ext;
   logic [SEND_W-1:0] send_n;

   // packet length and room check
   assign len4     = middle_ff || middle_chg_ff;
   assign fill_sum = {1'b0, count_ff} + (CNT_W + 1)'(len4 ? PKT_LEN4 : PKT_LEN3);

   // bytes to send: smallest of room, queue fill and the send limit
   assign room_lim  = (room_ff > MAX_SEND) ? MAX_SEND : room_ff;
   assign room_ext  = CMP_W'(room_lim);
   assign count_ext = CMP_W'(count_ff);
   assign send_n    = (count_ext < room_ext) ? SEND_W'(count_ext) : room_lim;

   assign status.fits       = (fill_sum <= DEPTH_EXT);
   assign status.write_last = (idx_ff == (len4_ff ? PKT_LAST4 : PKT_LAST3));
   assign status.send_zero  = (send_n == '0);
   assign status.more       = (left_n_ff != '0);

   assign rsp_out_byte = rd_data_ff;
   assign rsp_is_last  = (left_n_ff == '0);

   // motion accumulators and button state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         left_ff       <= 1'b0;
         right_ff      <= 1'b0;
         middle_ff     <= 1'b0;
         middle_chg_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (req_func == FUNC_MOTION) begin
            if (req_axis_select) begin
               sum_y_ff <= sum_y_ff + req_motion_value[7:0];
            end else begin
               sum_x_ff <= sum_x_ff + req_motion_value[7:0];
            end
         end else if (req_func == FUNC_BUTTON) begin
            unique case (req_button_select)
               BTN_LEFT: begin
                  left_ff <= req_button_down;
               end
               BTN_MIDDLE: begin
                  middle_ff     <= req_button_down;
                  middle_chg_ff <= 1'b1;
               end
               BTN_RIGHT: begin
                  right_ff <= req_button_down;
               end
               default: begin
                  // unused button codes leave the state alone
               end
            endcase
         end
      end else if (cmd.build) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         if (len4) begin
            middle_chg_ff <= 1'b0;
         end
      end
   end

   // latched room and packet bytes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         room_ff <= req_room;
      end
      if (cmd.build) begin
         pkt_ff[0] <= {PKT_HEAD_TAG, left_ff, right_ff, sum_y_ff[7:6], sum_x_ff[7:6]};
         pkt_ff[1] <= {2'b00, sum_x_ff[5:0]};
         pkt_ff[2] <= {2'b00, sum_y_ff[5:0]};
         pkt_ff[3] <= middle_ff ? PKT_MIDDLE_ON : 8'h00;
         len4_ff   <= len4;
      end
   end

   // queue pointers, fill count and send counter
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
         left_n_ff <= '0;
      end else begin
         if (cmd.build) begin
            idx_ff <= '0;
         end
         if (cmd.write) begin
            idx_ff   <= idx_ff + 2'd1;
            tail_ff  <= (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.calc) begin
            left_n_ff <= send_n;
         end
         if (cmd.read) begin
            head_ff   <= (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
            count_ff  <= count_ff - CNT_W'(1);
            left_n_ff <= left_n_ff - SEND_W'(1);
         end
      end
   end

   // byte queue storage, read data doubles as the output register
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[tail_ff] <= pkt_ff[idx_ff];
      end
      if (cmd.read) begin
         rd_data_ff <= mem[head_ff];
      end
   end

endmodule
